// ===== hdl/csrf_pkg.sv =====
// ----------------------------------------------------------------------------
// csrf_pkg
// shared types, codes and sizes for the clip stack rectangle fill front end
// ----------------------------------------------------------------------------
package csrf_pkg;

  // stack depth, base entry included
  localparam int CLIP_DEPTH    = 16;
  localparam int STACK_ENTRIES = CLIP_DEPTH - 1;
  localparam int ADDR_W        = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
  localparam int LEVEL_W       = $clog2(CLIP_DEPTH + 1);

  localparam int COORD_W   = 15;
  localparam int RECT_W    = 16;
  localparam int STRIDE_W  = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int COLOR_W   = 32;
  localparam int OFFSET_W  = 32;
  localparam int LEVEL_OUT_W = 5;
  // intersection math: sums of 16-bit signed and 15-bit unsigned values
  localparam int ISECT_W   = 18;
  // four bytes per pixel
  localparam int PIXEL_SHIFT = 2;

  // operation codes
  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_POP  = 2'd1;
  localparam logic [1:0] FUNC_FILL = 2'd2;
  // unused code, changes nothing
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // status codes
  localparam logic [1:0] STATUS_DONE       = 2'd0;
  localparam logic [1:0] STATUS_PUSH_FULL  = 2'd1;
  localparam logic [1:0] STATUS_POP_BASE   = 2'd2;
  localparam logic [1:0] STATUS_FILL_EMPTY = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE    = 2'd2;

  localparam logic [COORD_W-1:0]  CANVAS_WIDTH_RST  = 15'd640;
  localparam logic [COORD_W-1:0]  CANVAS_HEIGHT_RST = 15'd480;
  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST    = 17'd2560;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [RECT_W-1:0]  rect_x;
    logic signed [RECT_W-1:0]  rect_y;
    logic signed [RECT_W-1:0]  rect_w;
    logic signed [RECT_W-1:0]  rect_h;
    logic [COLOR_W-1:0]        fill_color;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   draw_valid;
    logic [COORD_W-1:0]     clip_x;
    logic [COORD_W-1:0]     clip_y;
    logic [COORD_W-1:0]     clip_w;
    logic [COORD_W-1:0]     clip_h;
    logic [OFFSET_W-1:0]    start_offset;
    logic [COLOR_W-1:0]     out_color;
    logic [LEVEL_OUT_W-1:0] stack_level;
  } out_item_t;

  // one stored clip entry
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } clip_rect_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ISECT,
    ST_EXEC,
    ST_FIN
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic read;
    logic isect;
    logic exec;
    logic fin;
  } cmd_t;

endpackage

// ===== hdl/csrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// csrf_ctrl
// sequencer: load, top clip read, intersect, commit, result
// ----------------------------------------------------------------------------
module csrf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output csrf_pkg::cmd_t  cmd
);

  csrf_pkg::state_t state_r;
  csrf_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csrf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      csrf_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = csrf_pkg::ST_READ;
        end
      end
      csrf_pkg::ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = csrf_pkg::ST_ISECT;
      end
      csrf_pkg::ST_ISECT: begin
        cmd.isect = 1'b1;
        state_nxt = csrf_pkg::ST_EXEC;
      end
      csrf_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = csrf_pkg::ST_FIN;
      end
      csrf_pkg::ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = csrf_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = csrf_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != csrf_pkg::ST_IDLE);

endmodule

// ===== hdl/csrf_dp.sv =====
// ----------------------------------------------------------------------------
// csrf_dp
// datapath: config registers, clip stack memory, intersect, offset multiply
// ----------------------------------------------------------------------------
module csrf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  csrf_pkg::cmd_t                      cmd,
  input  csrf_pkg::in_item_t                  in_item,
  input  logic                                cfg_we,
  input  logic [csrf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csrf_pkg::CFG_W-1:0]          cfg_data,
  output logic                                out_strobe,
  output csrf_pkg::out_item_t                 out_item
);

  localparam int IW = csrf_pkg::ISECT_W;
  localparam int CW = csrf_pkg::COORD_W;
  localparam int LW = csrf_pkg::LEVEL_W;

  logic [CW-1:0]                    canvas_w_r;
  logic [CW-1:0]                    canvas_h_r;
  logic [csrf_pkg::STRIDE_W-1:0]    stride_r;
  logic [LW-1:0]                    level_r;
  logic [LW-1:0]                    level_nxt;

  csrf_pkg::in_item_t               item_r;
  csrf_pkg::clip_rect_t             mem [csrf_pkg::STACK_ENTRIES];
  csrf_pkg::clip_rect_t             rd_r;
  csrf_pkg::clip_rect_t             top;
  csrf_pkg::clip_rect_t             wr_entry;
  logic [csrf_pkg::ADDR_W-1:0]      rd_addr;
  logic [csrf_pkg::ADDR_W-1:0]      wr_addr;
  logic                             at_base;
  logic                             push_ok;
  logic                             mem_we;

  logic signed [IW-1:0] ax, ay, aw, ah, tx, ty, tw, th;
  logic signed [IW-1:0] ar, ab, tr, tb, rx, ry, rw, rh;
  logic [CW-1:0]        cx_r, cy_r;
  logic signed [IW-1:0] cw_r, ch_r;
  logic [CW-1:0]        cw_clamp, ch_clamp;
  logic                 fill_ok;

  csrf_pkg::out_item_t            res_r;
  csrf_pkg::out_item_t            res_nxt;
  logic [csrf_pkg::OFFSET_W-1:0]  prod_r;
  csrf_pkg::out_item_t            out_r;
  csrf_pkg::out_item_t            out_nxt;
  logic                           out_strobe_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_w_r <= csrf_pkg::CANVAS_WIDTH_RST;
      canvas_h_r <= csrf_pkg::CANVAS_HEIGHT_RST;
      stride_r   <= csrf_pkg::ROW_STRIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csrf_pkg::CFG_CANVAS_WIDTH:  canvas_w_r <= cfg_data[CW-1:0];
        csrf_pkg::CFG_CANVAS_HEIGHT: canvas_h_r <= cfg_data[CW-1:0];
        csrf_pkg::CFG_ROW_STRIDE:    stride_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
  end

  // clip stack memory, top entry sits at level minus two
  assign at_base = (level_r < LW'(2));
  assign rd_addr = at_base ? '0 : csrf_pkg::ADDR_W'(level_r - LW'(2));
  assign wr_addr = csrf_pkg::ADDR_W'(level_r - LW'(1));
  assign push_ok = (level_r < LW'(csrf_pkg::CLIP_DEPTH));
  assign mem_we  = cmd.exec && (item_r.func == csrf_pkg::FUNC_PUSH) && push_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    if (cmd.read) begin
      rd_r <= mem[rd_addr];
    end
  end

  // base clip follows the canvas registers
  always_comb begin
    if (at_base) begin
      top.x = '0;
      top.y = '0;
      top.w = canvas_w_r;
      top.h = canvas_h_r;
    end else begin
      top = rd_r;
    end
  end

  // rectangle intersection
  assign ax = IW'(item_r.rect_x);
  assign ay = IW'(item_r.rect_y);
  assign aw = IW'(item_r.rect_w);
  assign ah = IW'(item_r.rect_h);
  assign tx = {{(IW-CW){1'b0}}, top.x};
  assign ty = {{(IW-CW){1'b0}}, top.y};
  assign tw = {{(IW-CW){1'b0}}, top.w};
  assign th = {{(IW-CW){1'b0}}, top.h};
  assign ar = ax + aw;
  assign ab = ay + ah;
  assign tr = tx + tw;
  assign tb = ty + th;
  assign rx = (ax > tx) ? ax : tx;
  assign ry = (ay > ty) ? ay : ty;
  assign rw = ((ar < tr) ? ar : tr) - rx;
  assign rh = ((ab < tb) ? ab : tb) - ry;

  // left and top are never below the clip's, which is never negative
  always_ff @(posedge clk) begin
    if (cmd.isect) begin
      cx_r <= rx[CW-1:0];
      cy_r <= ry[CW-1:0];
      cw_r <= rw;
      ch_r <= rh;
    end
  end

  assign cw_clamp = cw_r[IW-1] ? '0 : cw_r[CW-1:0];
  assign ch_clamp = ch_r[IW-1] ? '0 : ch_r[CW-1:0];
  assign fill_ok  = !cw_r[IW-1] && (cw_r != '0) && !ch_r[IW-1] && (ch_r != '0);

  assign wr_entry.x = cx_r;
  assign wr_entry.y = cy_r;
  assign wr_entry.w = cw_clamp;
  assign wr_entry.h = ch_clamp;

  // commit: stack update and result fields
  always_comb begin
    level_nxt = level_r;
    res_nxt   = '0;
    unique case (item_r.func)
      csrf_pkg::FUNC_PUSH: begin
        if (push_ok) begin
          level_nxt = level_r + LW'(1);
        end else begin
          res_nxt.status = csrf_pkg::STATUS_PUSH_FULL;
        end
      end
      csrf_pkg::FUNC_POP: begin
        if (at_base) begin
          res_nxt.status = csrf_pkg::STATUS_POP_BASE;
        end else begin
          level_nxt = level_r - LW'(1);
        end
      end
      csrf_pkg::FUNC_FILL: begin
        if (fill_ok) begin
          res_nxt.draw_valid = 1'b1;
          res_nxt.clip_x     = cx_r;
          res_nxt.clip_y     = cy_r;
          res_nxt.clip_w     = cw_r[CW-1:0];
          res_nxt.clip_h     = ch_r[CW-1:0];
          res_nxt.out_color  = item_r.fill_color;
        end else begin
          res_nxt.status = csrf_pkg::STATUS_FILL_EMPTY;
        end
      end
      default: ;
    endcase
    res_nxt.stack_level = csrf_pkg::LEVEL_OUT_W'(level_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LW'(1);
    end else if (cmd.exec) begin
      level_r <= level_nxt;
    end
  end

  // 15 x 17 row multiply fits 32 bits
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r  <= res_nxt;
      prod_r <= csrf_pkg::OFFSET_W'(cy_r * stride_r);
    end
  end

  // final offset add, zero when nothing is drawn
  always_comb begin
    out_nxt = res_r;
    if (res_r.draw_valid) begin
      out_nxt.start_offset = prod_r
        + (csrf_pkg::OFFSET_W'(res_r.clip_x) << csrf_pkg::PIXEL_SHIFT);
    end else begin
      out_nxt.start_offset = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.fin;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

// ===== hdl/clip_stack_rect_fill_front_end_top.sv =====
// ----------------------------------------------------------------------------
// clip_stack_rect_fill_front_end_top
// clip rectangle stack and fill rectangle clipping for a 2D fill engine
// ----------------------------------------------------------------------------
// An item (push clip, pop clip or fill rectangle) is taken when start is high
// and busy is low. Each item gives exactly one result, shown on out_item for a
// single cycle with out_strobe high; the receiver cannot stall it, so it must
// take the result in that cycle. From the accept edge to the strobe an item
// goes through latch, clip stack memory read, intersection, commit with the
// row multiply, and final offset add into the output register. busy stays
// high through the final offset add, so a new item is not taken before the
// last one is through; its result and the next accept may share a cycle.
// The base clip is the whole canvas and follows canvas_width/canvas_height at
// once; pushed entries keep the values they were stored with. Configuration
// writes go through cfg_we/cfg_index/cfg_data and take effect at the next edge;
// they should only be made while the block is idle.
// ----------------------------------------------------------------------------
module clip_stack_rect_fill_front_end_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // item channel
  input  logic                            start,
  output logic                            busy,
  input  csrf_pkg::in_item_t              in_item,
  // result channel
  output logic                            out_strobe,
  output csrf_pkg::out_item_t             out_item,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [csrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csrf_pkg::CFG_W-1:0]      cfg_data
);

  // commands from the sequencer to the datapath
  csrf_pkg::cmd_t cmd;

  // sequencer: one item at a time through a fixed five-step flow
  csrf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath: stack memory, intersection, offset math, result register
  csrf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ===== hdl/csrf_checker.sv =====
// ----------------------------------------------------------------------------
// csrf_checker
// port level checks for the clip stack rectangle fill front end
// ----------------------------------------------------------------------------
module csrf_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_strobe,
  input csrf_pkg::out_item_t  out_item
);

  // every accepted item gives its result
  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##5 out_strobe)
    else $error("accepted item gave no result");

  // results only come from an accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a pending item");

  // a drawn rectangle always reports done and non-zero size
  a_draw_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.draw_valid |->
      out_item.status == csrf_pkg::STATUS_DONE &&
      out_item.clip_w != '0 && out_item.clip_h != '0)
    else $error("draw result with bad status or empty size");

  // no drawing means all drawing fields are zero
  a_no_draw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.draw_valid |->
      out_item.clip_x == '0 && out_item.clip_y == '0 &&
      out_item.clip_w == '0 && out_item.clip_h == '0 &&
      out_item.start_offset == '0 && out_item.out_color == '0)
    else $error("non-draw result carries drawing fields");

  // stack level stays between base only and full
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_item.stack_level != '0 &&
      out_item.stack_level <= csrf_pkg::LEVEL_OUT_W'(csrf_pkg::CLIP_DEPTH))
    else $error("stack level out of range");

endmodule

bind clip_stack_rect_fill_front_end_top csrf_checker u_csrf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
